/* hw/rtl/uvtod_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and fixed widths of the UV triangle overlap detector.
// No dependencies; every other file of the block but uvtod_ram imports this package.
package uvtod_pkg;

    localparam int COORD_W   = 17;
    localparam int MODE_W    = 2;
    localparam int QUERY_W   = 14;
    localparam int PAIRS_W   = 14;
    localparam int STORED_W  = 15;
    localparam int MARGIN_W  = 8;
    localparam int NORM_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int PROJ_W    = PROD_W + 1;
    localparam int DIFF_W    = PROJ_W + 1;
    localparam int CORNERS   = 3;
    localparam int AXES      = 6;

    localparam logic [PAIRS_W-1:0] PAIRS_MAX = {PAIRS_W{1'b1}};

    localparam int DEF_MAX_FACES       = 16384;
    localparam int DEF_GRID_CELLS      = 64;
    localparam int DEF_CELL_DEPTH      = 16;
    localparam int DEF_COORD_FRAC_BITS = 16;

    typedef logic [COORD_W-1:0] coord_t;
    // Corner order: u0, v0, u1, v1, u2, v2 at indexes 0 to 5
    typedef coord_t [2*CORNERS-1:0] tri_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CELL_FULL  = 2'd1,
        ST_STORE_FULL = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_FILL_W,
        S_ENT,
        S_LIST_W,
        S_META_W,
        S_SAT,
        S_APPEND,
        S_FINISH,
        S_QRY_W,
        S_DONE
    } state_t;

    typedef struct packed {
        logic done;
        logic overlap;
    } sat_status_t;

endpackage

/* hw/rtl/uv_triangle_overlap_detector_core.sv */
`timescale 1ns / 1ps
// Top level of the UV triangle overlap detector: grid walk, face store, results.
// Depends on uvtod_pkg, uvtod_ram and uvtod_sat.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data (overlap margin)
//  in      | in        | in_valid/in_stall  | mode, u0..v2, query_face
//  out     | out       | out_valid/out_stall| status, overlap_found, pairs_found,
//          |           |                    | face_bad, faces_stored
//
// One transaction at a time. An add reads the fill of each covered cell, then for
// each listed face reads the list and meta memories and, unless skipped, runs the
// six-axis unit; a read looks up the meta word of the queried face. Registered
// memory reads in series and the axis unit set how long each transaction takes.
// After reset and after a clear, a pass over max(GRID_CELLS^2, MAX_FACES) addresses
// (16384 by default) empties the cell fill and face meta memories; no input is taken.
// The result register holds while out_stall is high; the next input may be taken then.
module uv_triangle_overlap_detector_core #(
    parameter int MAX_FACES       = uvtod_pkg::DEF_MAX_FACES,
    parameter int GRID_CELLS      = uvtod_pkg::DEF_GRID_CELLS,
    parameter int CELL_DEPTH      = uvtod_pkg::DEF_CELL_DEPTH,
    parameter int COORD_FRAC_BITS = uvtod_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uvtod_pkg::MARGIN_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [uvtod_pkg::MODE_W-1:0]       mode,
    input  logic [uvtod_pkg::COORD_W-1:0]      u0,
    input  logic [uvtod_pkg::COORD_W-1:0]      v0,
    input  logic [uvtod_pkg::COORD_W-1:0]      u1,
    input  logic [uvtod_pkg::COORD_W-1:0]      v1,
    input  logic [uvtod_pkg::COORD_W-1:0]      u2,
    input  logic [uvtod_pkg::COORD_W-1:0]      v2,
    input  logic [uvtod_pkg::QUERY_W-1:0]      query_face,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic                               overlap_found,
    output logic [uvtod_pkg::PAIRS_W-1:0]      pairs_found,
    output logic                               face_bad,
    output logic [uvtod_pkg::STORED_W-1:0]     faces_stored
);
    import uvtod_pkg::*;

    localparam int FACE_W     = $clog2(MAX_FACES);
    localparam int CNT_W      = $clog2(MAX_FACES + 1);
    localparam int META_W     = CNT_W + 1;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int GP_W       = $clog2(GRID_CELLS + 1);
    localparam int CP_W       = COORD_W + GP_W;
    localparam int NCELLS     = GRID_CELLS * GRID_CELLS;
    localparam int NCELL_W    = $clog2(NCELLS);
    localparam int LIST_DEPTH = NCELLS * CELL_DEPTH;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);
    localparam int FILL_W     = $clog2(CELL_DEPTH + 1);
    localparam int CLR_N      = (NCELLS > MAX_FACES) ? NCELLS : MAX_FACES;
    localparam int CLR_W      = $clog2(CLR_N);
    localparam logic [CNT_W-1:0] SENTINEL = CNT_W'(MAX_FACES);

    function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] c);
        logic [CP_W-1:0] p;
        logic [CP_W-1:0] s;
        p = CP_W'(c) * CP_W'(GRID_CELLS);
        s = p >> COORD_FRAC_BITS;
        if (s > CP_W'(GRID_CELLS - 1)) cell_of = CELL_W'(GRID_CELLS - 1);
        else cell_of = CELL_W'(s);
    endfunction

    function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    state_t               state_reg, state_next;
    logic [MARGIN_W-1:0]  margin_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [FACE_W-1:0]    f_reg, f_next;
    tri_t                 tri_reg, tri_next;
    logic [CELL_W-1:0]    x0_reg, x1_reg, y1_reg, x_reg, y_reg;
    logic [CELL_W-1:0]    x0_next, x1_next, y1_next, x_next, y_next;
    logic [FILL_W-1:0]    n_reg, n_next, e_reg, e_next;
    logic [FACE_W-1:0]    other_reg, other_next;
    logic                 bad_f_reg, bad_f_next;
    logic [PAIRS_W-1:0]   pairs_reg, pairs_next;
    status_t              stacc_reg, stacc_next;
    logic [CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 clr_reply_reg, clr_reply_next;
    status_t              res_st_reg, res_st_next;
    logic                 res_found_reg, res_found_next;
    logic [PAIRS_W-1:0]   res_pairs_reg, res_pairs_next;
    logic                 res_bad_reg, res_bad_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_st_reg;
    logic                 out_found_reg, out_bad_reg;
    logic [PAIRS_W-1:0]   out_pairs_reg;
    logic [STORED_W-1:0]  out_stored_reg;
    logic                 out_load;

    tri_t                 in_tri;
    logic                 in_accept;
    logic [NCELL_W-1:0]   cell_num;
    logic [LIST_AW-1:0]   list_base;

    logic                 corner_we;
    logic [FACE_W-1:0]    corner_raddr;
    tri_t                 corner_rdata;
    logic                 meta_we;
    logic [FACE_W-1:0]    meta_waddr, meta_raddr;
    logic [META_W-1:0]    meta_wdata, meta_rdata;
    logic                 list_we;
    logic [LIST_AW-1:0]   list_waddr, list_raddr;
    logic [FACE_W-1:0]    list_rdata;
    logic                 fill_we;
    logic [NCELL_W-1:0]   fill_waddr;
    logic [FILL_W-1:0]    fill_wdata, fill_rdata;

    logic                 sat_start;
    sat_status_t          sat_stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_tri    = {v2, u2, v1, u1, v0, u0};

    assign cell_num  = NCELL_W'(NCELL_W'(y_reg) * NCELL_W'(GRID_CELLS)) + NCELL_W'(x_reg);
    assign list_base = LIST_AW'(LIST_AW'(cell_num) * LIST_AW'(CELL_DEPTH));

    uvtod_ram #(.WIDTH($bits(tri_t)), .DEPTH(MAX_FACES)) u_corner (
        .clk   (clk),
        .we    (corner_we),
        .waddr (FACE_W'(count_reg)),
        .wdata (in_tri),
        .raddr (corner_raddr),
        .rdata (corner_rdata)
    );

    // Per face: bad flag on top, last testing face below
    uvtod_ram #(.WIDTH(META_W), .DEPTH(MAX_FACES)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    uvtod_ram #(.WIDTH(FACE_W), .DEPTH(LIST_DEPTH)) u_list (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (f_reg),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    uvtod_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (cell_num),
        .rdata (fill_rdata)
    );

    uvtod_sat u_sat (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sat_start),
        .tri_a  (tri_reg),
        .tri_b  (corner_rdata),
        .margin (margin_reg),
        .stat   (sat_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        f_next         = f_reg;
        tri_next       = tri_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        n_next         = n_reg;
        e_next         = e_reg;
        other_next     = other_reg;
        bad_f_next     = bad_f_reg;
        pairs_next     = pairs_reg;
        stacc_next     = stacc_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        res_st_next    = res_st_reg;
        res_found_next = res_found_reg;
        res_pairs_next = res_pairs_reg;
        res_bad_next   = res_bad_reg;
        out_load       = 1'b0;
        corner_we      = 1'b0;
        corner_raddr   = other_reg;
        meta_we        = 1'b0;
        meta_waddr     = other_reg;
        meta_wdata     = {bad_f_reg, CNT_W'(f_reg)};
        meta_raddr     = other_reg;
        list_we        = 1'b0;
        list_waddr     = list_base + LIST_AW'(n_reg);
        list_raddr     = list_base + LIST_AW'(e_reg);
        fill_we        = 1'b0;
        fill_waddr     = cell_num;
        fill_wdata     = n_reg + FILL_W'(1);
        sat_start      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                if ({1'b0, clr_cnt_reg} < (CLR_W+1)'(NCELLS))
                begin
                    fill_we    = 1'b1;
                    fill_waddr = NCELL_W'(clr_cnt_reg);
                    fill_wdata = '0;
                end
                if ({1'b0, clr_cnt_reg} < (CLR_W+1)'(MAX_FACES))
                begin
                    meta_we    = 1'b1;
                    meta_waddr = FACE_W'(clr_cnt_reg);
                    meta_wdata = {1'b0, SENTINEL};
                end
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(CLR_N - 1))
                begin
                    count_next = '0;
                    if (clr_reply_reg)
                    begin
                        res_st_next    = ST_OK;
                        res_found_next = 1'b0;
                        res_pairs_next = '0;
                        res_bad_next   = 1'b0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_st_next    = ST_OK;
                    res_found_next = 1'b0;
                    res_pairs_next = '0;
                    res_bad_next   = 1'b0;
                    unique case (mode_t'(mode))
                        MODE_ADD:
                        begin
                            if (count_reg >= SENTINEL)
                            begin
                                res_st_next = ST_STORE_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                corner_we  = 1'b1;
                                f_next     = FACE_W'(count_reg);
                                tri_next   = in_tri;
                                x0_next    = cell_of(min3(u0, u1, u2));
                                x1_next    = cell_of(max3(u0, u1, u2));
                                y1_next    = cell_of(max3(v0, v1, v2));
                                x_next     = cell_of(min3(u0, u1, u2));
                                y_next     = cell_of(min3(v0, v1, v2));
                                bad_f_next = 1'b0;
                                pairs_next = '0;
                                stacc_next = ST_OK;
                                state_next = S_CELL;
                            end
                        end
                        MODE_READ:
                        begin
                            meta_raddr = FACE_W'(query_face);
                            if (32'(query_face) >= 32'(count_reg) ||
                                32'(query_face) >= 32'(MAX_FACES))
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_QRY_W;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            clr_cnt_next   = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        MODE_NONE:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                // fill read is addressed by cell_num
                state_next = S_FILL_W;
            end
            S_FILL_W:
            begin
                n_next     = fill_rdata;
                e_next     = '0;
                state_next = S_ENT;
            end
            S_ENT:
            begin
                if (e_reg < n_reg)
                begin
                    state_next = S_LIST_W;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_LIST_W:
            begin
                other_next   = list_rdata;
                meta_raddr   = list_rdata;
                corner_raddr = list_rdata;
                state_next   = S_META_W;
            end
            S_META_W:
            begin
                if (meta_rdata[CNT_W-1:0] == CNT_W'(f_reg))
                begin
                    e_next     = e_reg + FILL_W'(1);
                    state_next = S_ENT;
                end
                else if (bad_f_reg && meta_rdata[META_W-1])
                begin
                    // both already bad: mark tested, skip the axis work
                    meta_we    = 1'b1;
                    meta_wdata = {1'b1, CNT_W'(f_reg)};
                    e_next     = e_reg + FILL_W'(1);
                    state_next = S_ENT;
                end
                else
                begin
                    sat_start = 1'b1;
                    res_bad_next = meta_rdata[META_W-1];
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (sat_stat.done)
                begin
                    meta_we = 1'b1;
                    if (sat_stat.overlap)
                    begin
                        meta_wdata = {1'b1, CNT_W'(f_reg)};
                        bad_f_next = 1'b1;
                        if (pairs_reg != PAIRS_MAX) pairs_next = pairs_reg + PAIRS_W'(1);
                    end
                    else
                    begin
                        meta_wdata = {res_bad_reg, CNT_W'(f_reg)};
                    end
                    e_next     = e_reg + FILL_W'(1);
                    state_next = S_ENT;
                end
            end
            S_APPEND:
            begin
                if (n_reg < FILL_W'(CELL_DEPTH))
                begin
                    list_we = 1'b1;
                    fill_we = 1'b1;
                end
                else
                begin
                    stacc_next = ST_CELL_FULL;
                end
                if (x_reg != x1_reg)
                begin
                    x_next     = x_reg + CELL_W'(1);
                    state_next = S_CELL;
                end
                else if (y_reg != y1_reg)
                begin
                    x_next     = x0_reg;
                    y_next     = y_reg + CELL_W'(1);
                    state_next = S_CELL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                meta_we        = 1'b1;
                meta_waddr     = f_reg;
                meta_wdata     = {bad_f_reg, SENTINEL};
                res_st_next    = stacc_reg;
                res_found_next = bad_f_reg;
                res_pairs_next = pairs_reg;
                res_bad_next   = bad_f_reg;
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_DONE;
            end
            S_QRY_W:
            begin
                res_bad_next = meta_rdata[META_W-1];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall) out_valid_next = 1'b0;
        if (out_load) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            margin_reg    <= '0;
            count_reg     <= '0;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            bad_f_reg     <= 1'b0;
            pairs_reg     <= '0;
            stacc_reg     <= ST_OK;
            e_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            bad_f_reg     <= bad_f_next;
            pairs_reg     <= pairs_next;
            stacc_reg     <= stacc_next;
            e_reg         <= e_next;
            n_reg         <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                margin_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg         <= f_next;
        tri_reg       <= tri_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        other_reg     <= other_next;
        res_st_reg    <= res_st_next;
        res_found_reg <= res_found_next;
        res_pairs_reg <= res_pairs_next;
        res_bad_reg   <= res_bad_next;
        if (out_load)
        begin
            out_st_reg     <= res_st_reg;
            out_found_reg  <= res_found_reg;
            out_pairs_reg  <= res_pairs_reg;
            out_bad_reg    <= res_bad_reg;
            out_stored_reg <= STORED_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign overlap_found = out_found_reg;
    assign pairs_found   = out_pairs_reg;
    assign face_bad      = out_bad_reg;
    assign faces_stored  = out_stored_reg;

    a_pairs_imply_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pairs_found == '0) || overlap_found)
        else $error("pairs counted without overlap flag");

    a_range_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_RANGE) |-> !face_bad)
        else $error("out-of-range query reports a bad face");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SENTINEL)
        else $error("face count beyond store depth");

    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENT) |-> (e_reg <= n_reg) && (n_reg <= FILL_W'(CELL_DEPTH)))
        else $error("cell entry walk beyond fill");

endmodule

/* hw/rtl/uvtod_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module uvtod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/uvtod_sat.sv */
`timescale 1ns / 1ps
// Six-axis separating-axis test of two triangles, one axis at a time through normal, products, projections and compare.
// Depends on uvtod_pkg.
module uvtod_sat (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  uvtod_pkg::tri_t                     tri_a,
    input  uvtod_pkg::tri_t                     tri_b,
    input  logic [uvtod_pkg::MARGIN_W-1:0]      margin,
    output uvtod_pkg::sat_status_t              stat
);
    import uvtod_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     sep_reg, sep_next;
    logic [2:0]               axis_reg, axis_next;
    logic [1:0]               phase_reg, phase_next;

    tri_t                     a_reg, b_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic signed [PROD_W-1:0] pu_reg [2*CORNERS];
    logic signed [PROD_W-1:0] pv_reg [2*CORNERS];
    logic signed [PROJ_W-1:0] proj_reg [2*CORNERS];

    tri_t                     edge_tri;
    logic [2:0]               iu, iv, ju, jv;
    logic signed [PROJ_W-1:0] amin, amax, bmin, bmax, hi, lo;
    logic signed [DIFF_W-1:0] gap, lim;

    // Edge normal of the current axis
    always_comb
    begin
        edge_tri = (axis_reg < 3'd3) ? a_reg : b_reg;
        unique case (axis_reg)
            3'd0, 3'd3: begin iu = 3'd0; ju = 3'd2; end
            3'd1, 3'd4: begin iu = 3'd2; ju = 3'd4; end
            3'd2, 3'd5: begin iu = 3'd4; ju = 3'd0; end
            default:    begin iu = 3'd0; ju = 3'd2; end
        endcase
        iv = iu + 3'd1;
        jv = ju + 3'd1;
        nx_next = $signed({1'b0, edge_tri[jv]}) - $signed({1'b0, edge_tri[iv]});
        ny_next = $signed({1'b0, edge_tri[iu]}) - $signed({1'b0, edge_tri[ju]});
    end

    // Interval overlap on the current axis
    always_comb
    begin
        amin = proj_reg[0];
        amax = proj_reg[0];
        bmin = proj_reg[3];
        bmax = proj_reg[3];
        for (int c = 1; c < CORNERS; c++)
        begin
            if (proj_reg[c] < amin) amin = proj_reg[c];
            if (proj_reg[c] > amax) amax = proj_reg[c];
            if (proj_reg[3+c] < bmin) bmin = proj_reg[3+c];
            if (proj_reg[3+c] > bmax) bmax = proj_reg[3+c];
        end
        hi  = (amax < bmax) ? amax : bmax;
        lo  = (amin > bmin) ? amin : bmin;
        gap = DIFF_W'(hi) - DIFF_W'(lo);
        lim = $signed({{(DIFF_W-MARGIN_W){1'b0}}, margin});
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        sep_next   = sep_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            sep_next   = 1'b0;
            axis_next  = 3'd0;
            phase_next = 2'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                if (gap <= lim) sep_next = 1'b1;
                if (axis_reg == 3'(AXES - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    axis_next = axis_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            sep_reg   <= 1'b0;
            axis_reg  <= 3'd0;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            sep_reg   <= sep_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
        end
    end

    // Datapath: normal, products, projections
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= tri_a;
            b_reg <= tri_b;
        end
        if (busy_reg && phase_reg == 2'd0)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
        if (busy_reg && phase_reg == 2'd1)
        begin
            for (int c = 0; c < CORNERS; c++)
            begin
                pu_reg[c]   <= $signed({1'b0, a_reg[2*c]}) * nx_reg;
                pv_reg[c]   <= $signed({1'b0, a_reg[2*c+1]}) * ny_reg;
                pu_reg[3+c] <= $signed({1'b0, b_reg[2*c]}) * nx_reg;
                pv_reg[3+c] <= $signed({1'b0, b_reg[2*c+1]}) * ny_reg;
            end
        end
        if (busy_reg && phase_reg == 2'd2)
        begin
            for (int k = 0; k < 2*CORNERS; k++)
            begin
                proj_reg[k] <= PROJ_W'(pu_reg[k]) + PROJ_W'(pv_reg[k]);
            end
        end
    end

    assign stat.done    = done_reg;
    assign stat.overlap = !sep_reg;

endmodule

/* sim/uv_triangle_overlap_detector_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for uv_triangle_overlap_detector_core: directed,
// cell-fill and random phases against an in-bench overlap predictor.
// Depends on uvtod_pkg and the RTL of the detector.
module uv_triangle_overlap_detector_core_tb;

    import uvtod_pkg::*;

    localparam int NFACES     = DEF_MAX_FACES;
    localparam int NGRID      = DEF_GRID_CELLS;
    localparam int NDEPTH     = DEF_CELL_DEPTH;
    localparam int FRAC       = DEF_COORD_FRAC_BITS;
    localparam int NCELLS     = NGRID * NGRID;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int FILL_FACES  = 64;
    localparam int PHASE_ITEMS = 280;

    typedef struct {
        mode_t               op;
        tri_t                corners;
        logic [QUERY_W-1:0]  query;
    } uv_item_t;

    typedef struct {
        status_t              st;
        logic                 found;
        logic [PAIRS_W-1:0]   pairs;
        logic                 bad;
        logic [STORED_W-1:0]  stored;
    } uv_result_t;

    class overlap_tracker;
        tri_t              face_tri [NFACES];
        int unsigned       cell_face [NCELLS][NDEPTH];
        int unsigned       cell_count [NCELLS];
        int unsigned       tested_by [NFACES];
        bit                bad_face [NFACES];
        int unsigned       face_count;
        logic [MARGIN_W-1:0] margin;
        uv_result_t        expected_results [$];
        int                mismatches;

        function void wipe();
            for (int i = 0; i < NCELLS; i++)
                cell_count[i] = 0;
            for (int i = 0; i < NFACES; i++)
            begin
                tested_by[i] = NFACES;
                bad_face[i]  = 0;
            end
            face_count = 0;
        endfunction

        function bit apart_on(tri_t a, tri_t b, tri_t e, int i);
            int     j;
            longint nx, ny, ap, bp, amin, amax, bmin, bmax, hi, lo;
            j  = (i + 1) % 3;
            nx = longint'(e[2*j+1]) - longint'(e[2*i+1]);
            ny = longint'(e[2*i]) - longint'(e[2*j]);
            for (int c = 0; c < 3; c++)
            begin
                ap = longint'(a[2*c]) * nx + longint'(a[2*c+1]) * ny;
                bp = longint'(b[2*c]) * nx + longint'(b[2*c+1]) * ny;
                if (c == 0 || ap < amin) amin = ap;
                if (c == 0 || ap > amax) amax = ap;
                if (c == 0 || bp < bmin) bmin = bp;
                if (c == 0 || bp > bmax) bmax = bp;
            end
            hi = (amax < bmax) ? amax : bmax;
            lo = (amin > bmin) ? amin : bmin;
            return (hi - lo) <= longint'(margin);
        endfunction

        function bit overlaps(tri_t a, tri_t b);
            for (int i = 0; i < 3; i++)
                if (apart_on(a, b, a, i)) return 0;
            for (int i = 0; i < 3; i++)
                if (apart_on(a, b, b, i)) return 0;
            return 1;
        endfunction

        function int unsigned cell_index(coord_t c);
            longint unsigned k;
            k = (longint'(c) * NGRID) >> FRAC;
            return (k > NGRID - 1) ? NGRID - 1 : int'(k);
        endfunction

        function void take_item(uv_item_t it);
            uv_result_t  r;
            int unsigned f, x0, x1, y0, y1, cell_id, n, other;
            coord_t      lo_u, hi_u, lo_v, hi_v;
            r = '{ST_OK, 1'b0, '0, 1'b0, '0};
            case (it.op)
                MODE_ADD:
                begin
                    if (face_count >= NFACES)
                        r.st = ST_STORE_FULL;
                    else
                    begin
                        f = face_count;
                        face_tri[f] = it.corners;
                        lo_u = it.corners[0]; hi_u = it.corners[0];
                        lo_v = it.corners[1]; hi_v = it.corners[1];
                        for (int c = 1; c < 3; c++)
                        begin
                            if (it.corners[2*c] < lo_u) lo_u = it.corners[2*c];
                            if (it.corners[2*c] > hi_u) hi_u = it.corners[2*c];
                            if (it.corners[2*c+1] < lo_v) lo_v = it.corners[2*c+1];
                            if (it.corners[2*c+1] > hi_v) hi_v = it.corners[2*c+1];
                        end
                        x0 = cell_index(lo_u); x1 = cell_index(hi_u);
                        y0 = cell_index(lo_v); y1 = cell_index(hi_v);
                        for (int unsigned y = y0; y <= y1; y++)
                            for (int unsigned x = x0; x <= x1; x++)
                            begin
                                cell_id = y * NGRID + x;
                                n = cell_count[cell_id];
                                for (int unsigned e = 0; e < n && e < NDEPTH; e++)
                                begin
                                    other = cell_face[cell_id][e];
                                    if (other >= NFACES || tested_by[other] == f)
                                        continue;
                                    tested_by[other] = f;
                                    if (bad_face[f] && bad_face[other])
                                        continue;
                                    if (overlaps(it.corners, face_tri[other]))
                                    begin
                                        bad_face[f] = 1;
                                        bad_face[other] = 1;
                                        if (r.pairs != PAIRS_MAX) r.pairs++;
                                    end
                                end
                                if (n < NDEPTH)
                                begin
                                    cell_face[cell_id][n] = f;
                                    cell_count[cell_id] = n + 1;
                                end
                                else
                                    r.st = ST_CELL_FULL;
                            end
                        r.found = bad_face[f];
                        r.bad   = bad_face[f];
                        face_count = f + 1;
                    end
                end
                MODE_READ:
                begin
                    if (it.query >= face_count)
                        r.st = ST_RANGE;
                    else
                        r.bad = bad_face[it.query];
                end
                MODE_CLEAR:
                    wipe();
                default: ;
            endcase
            r.stored = face_count[STORED_W-1:0];
            expected_results = {expected_results, r};
        endfunction

        function void match_result(uv_result_t got);
            uv_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: status %0d stored %0d",
                             got.st, got.stored);
                return;
            end
            want = expected_results.pop_front();
            if (got.st !== want.st || got.found !== want.found ||
                got.pairs !== want.pairs || got.bad !== want.bad ||
                got.stored !== want.stored)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected status %0d found %0d pairs %0d bad %0d ",
                              "stored %0d, got %0d %0d %0d %0d %0d"},
                             want.st, want.found, want.pairs, want.bad, want.stored,
                             got.st, got.found, got.pairs, got.bad, got.stored);
            end
        endfunction
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [MARGIN_W-1:0]  cfg_data = '0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode = '0;
    coord_t               u0 = '0, v0 = '0, u1 = '0, v1 = '0, u2 = '0, v2 = '0;
    logic [QUERY_W-1:0]   query_face = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    logic [1:0]           status;
    logic                 overlap_found;
    logic [PAIRS_W-1:0]   pairs_found;
    logic                 face_bad;
    logic [STORED_W-1:0]  faces_stored;

    overlap_tracker tracker = new();
    longint cycles = 0;
    bit     no_idle = 0;
    bit     hold_req = 0;
    bit     hold_on = 0;

    uv_triangle_overlap_detector_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .u0(u0), .v0(v0), .u1(u1), .v1(v1), .u2(u2), .v2(v2),
        .query_face(query_face),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .overlap_found(overlap_found), .pairs_found(pairs_found),
        .face_bad(face_bad), .faces_stored(faces_stored)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles > CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Long receiver hold-off, counted here while the sender goes on sending.
    initial
    begin
        wait (hold_req);
        hold_on = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 0;
    end

    initial
    begin
        int stall_left, free_left;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_on)
                out_stall <= 1;
            else if (no_idle)
                out_stall <= 0;
            else if (stall_left > 0)
            begin
                out_stall <= 1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 0;
                free_left--;
            end
            else
            begin
                out_stall <= 0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 3);
                free_left  = $urandom_range(0, 30);
            end
        end
    end

    // Sample on the falling edge; the transaction completes at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_result('{status_t'(status), overlap_found, pairs_found,
                                   face_bad, faces_stored});
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(uv_item_t it);
        int gap;
        in_valid   <= 1;
        mode       <= it.op;
        u0 <= it.corners[0]; v0 <= it.corners[1];
        u1 <= it.corners[2]; v1 <= it.corners[3];
        u2 <= it.corners[4]; v2 <= it.corners[5];
        query_face <= it.query;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        tracker.take_item(it);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 0;
        while (tracker.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_margin(logic [MARGIN_W-1:0] value);
        drain_results();
        repeat (40) @(posedge clk);
        cfg_valid <= 1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 0;
        tracker.margin = value;
    endtask

    function automatic uv_item_t make_tri(int unsigned a0, int unsigned b0,
                                          int unsigned a1, int unsigned b1,
                                          int unsigned a2, int unsigned b2);
        uv_item_t it;
        it.op = MODE_ADD;
        it.corners = {coord_t'(b2), coord_t'(a2), coord_t'(b1), coord_t'(a1),
                      coord_t'(b0), coord_t'(a0)};
        it.query = QUERY_W'($urandom);
        return it;
    endfunction

    function automatic uv_item_t make_op(mode_t op, int unsigned q);
        uv_item_t it;
        it.op = op;
        for (int k = 0; k < 6; k++)
            it.corners[k] = coord_t'($urandom);
        it.query = QUERY_W'(q);
        return it;
    endfunction

    function automatic int unsigned near(int unsigned base, int unsigned span);
        int unsigned c;
        c = base + $urandom_range(0, span);
        return (c > 131071) ? 131071 : c;
    endfunction

    function automatic uv_item_t random_item();
        int unsigned r, bu, bv, span, spot;
        r = $urandom_range(0, 999);
        if (r < 700)
        begin
            spot = $urandom_range(0, 9);
            if (spot < 7)
            begin
                // Dense clusters: cells fill up and many pairs meet.
                bu = spot * 9000 + 2000 + $urandom_range(0, 1500);
                bv = spot * 7000 + 1000 + $urandom_range(0, 1500);
            end
            else
            begin
                bu = $urandom_range(0, 131071);
                bv = $urandom_range(0, 131071);
            end
            span = ($urandom_range(0, 3) == 0) ? 2047 : 600;
            return make_tri(near(bu, span), near(bv, span), near(bu, span),
                            near(bv, span), near(bu, span), near(bv, span));
        end
        if (r < 930)
            return make_op(MODE_READ, (tracker.face_count == 0) ? 0 :
                           $urandom_range(0, tracker.face_count - 1));
        if (r < 970)
            return make_op(MODE_READ, $urandom_range(0, 16383));
        if (r < 996)
            return make_op(MODE_NONE, $urandom_range(0, 16383));
        return make_op(MODE_CLEAR, 0);
    endfunction

    initial
    begin
        int unsigned k, x, y;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every mode and the named corner cases.
        write_margin(0);
        send_item(make_tri(0, 0, 65536, 0, 0, 65536));
        send_item(make_tri(0, 0, 65536, 0, 0, 65536));
        send_item(make_tri(131071, 131071, 131071, 70000, 70000, 131071));
        send_item(make_tri(131071, 131071, 131071, 70000, 70000, 131071));
        send_item(make_tri(3000, 3000, 3000, 3000, 3000, 3000));
        send_item(make_tri(100, 100, 900, 100, 100, 900));
        send_item(make_tri(900, 100, 900, 900, 100, 900));
        send_item(make_op(MODE_READ, 0));
        send_item(make_op(MODE_READ, 5));
        send_item(make_op(MODE_READ, 16383));
        send_item(make_op(MODE_NONE, 16383));
        send_item(make_op(MODE_CLEAR, 0));
        send_item(make_op(MODE_READ, 0));
        for (int i = 0; i < 18; i++)
            send_item(make_tri(200, 200, 700, 250, 300, 800));
        write_margin(255);
        send_item(make_tri(100, 100, 900, 100, 100, 900));
        send_item(make_tri(900, 100, 900, 900, 100, 900));
        send_item(make_tri(5000, 5000, 5010, 5000, 5000, 5010));

        // Fill a row of cells four faces to a cell, back to back.
        write_margin(0);
        send_item(make_op(MODE_CLEAR, 0));
        drain_results();
        no_idle = 1;
        for (int i = 0; i < FILL_FACES; i++)
        begin
            k = i / 4;
            x = (k % NGRID) * 1024;
            y = (k / NGRID) * 1024;
            send_item(make_tri(x + 100, y + 100, x + 800, y + 100, x + 100, y + 800));
        end
        no_idle = 0;
        send_item(make_tri(0, 0, 500, 0, 0, 500));
        send_item(make_tri(131071, 131071, 0, 0, 65536, 0));
        send_item(make_op(MODE_READ, 16383));
        send_item(make_op(MODE_READ, 2));
        send_item(make_op(MODE_CLEAR, 0));

        // Random phases under several margins, one with a long output hold-off.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_margin(0);
                1: write_margin(MARGIN_W'($urandom_range(1, 254)));
                2: write_margin(255);
                default: write_margin(MARGIN_W'($urandom));
            endcase
            if (phase == 1)
                hold_req = 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 3 && i >= 100 && i < 160)
                    no_idle = 1;
                else
                    no_idle = 0;
                send_item(random_item());
            end
            no_idle = 0;
            drain_results();
        end

        repeat (200) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
